[hw/rtl/assert_macros.svh]
// Assertion macros included by the top-level flattener.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

[hw/rtl/bpf_pkg.sv]
// Types, constants and helper functions of the Bezier path flattener.
package bpf_pkg;

  localparam int MAX_STEPS = 64;
  localparam int N_W       = $clog2(MAX_STEPS + 1);
  localparam int NSQ_W     = $clog2(MAX_STEPS * MAX_STEPS + 1);
  localparam int N4_W      = 2 * NSQ_W;
  localparam int DEN_W     = $clog2(MAX_STEPS * MAX_STEPS * MAX_STEPS + 1);
  localparam int W_W       = DEN_W + 1;

  localparam int COORD_W   = 22;
  localparam int PT_W      = 32;
  localparam int DIFF_W    = 34;
  localparam int CL_W      = 27;
  localparam int SQ_W      = 51;
  localparam int RHS_W     = 56;
  localparam int ACC_W     = 53;
  localparam int QUO_W     = 33;
  localparam int DCNT_W    = 6;

  localparam int SHIFT_QUAD  = 24;
  localparam int SHIFT_CUBIC = 22;
  localparam logic signed [DIFF_W-1:0] CLAMP_DIFF = DIFF_W'(33554432);

  localparam logic [0:0] REG_ORIGIN_X = 1'd0;
  localparam logic [0:0] REG_ORIGIN_Y = 1'd1;

  typedef enum logic [2:0] {
    KIND_MOVE  = 3'd0,
    KIND_LINE  = 3'd1,
    KIND_QUAD  = 3'd2,
    KIND_CUBIC = 3'd3,
    KIND_CLOSE = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    END_START,
    END_TO,
    END_CURVE
  } end_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAP,
    ST_CLOSE_EDGE,
    ST_FINISH,
    ST_LINE_EDGE,
    ST_DIFF,
    ST_SQR,
    ST_RHS,
    ST_SEARCH,
    ST_DEN,
    ST_WGT1,
    ST_WGT2,
    ST_MAC,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_STEP_EDGE
  } state_t;

  typedef struct packed {
    logic     load;
    logic     map;
    logic     diff;
    logic     sqr;
    logic     rhs;
    logic     search;
    logic     den;
    logic     wgt1;
    logic     wgt2;
    logic     mac;
    logic     div_start;
    logic     emit;
    end_sel_t end_sel;
    logic     last;
    logic     set_point;
    logic     clear_open;
    logic     step_next;
    logic     cubic;
  } cmd_t;

  typedef struct packed {
    logic close_due;
    logic search_hit;
    logic div_busy;
    logic mac_last;
    logic step_last;
    logic out_free;
  } sts_t;

  // Saturate a 26.6 difference scaled by 1024 into signed Q16.16.
  function automatic logic [PT_W-1:0] map_sat(input logic signed [COORD_W:0] d);
    logic [PT_W-1:0] r;
    if (d[COORD_W] != d[COORD_W-1]) begin
      r = d[COORD_W] ? {1'b1, {(PT_W-1){1'b0}}} : {1'b0, {(PT_W-1){1'b1}}};
    end else begin
      r = {d[COORD_W-1:0], 10'b0};
    end
    return r;
  endfunction

  function automatic logic signed [CL_W-1:0] clamp_diff(input logic signed [DIFF_W-1:0] d);
    logic signed [CL_W-1:0] r;
    if (d > CLAMP_DIFF) begin
      r = CL_W'(CLAMP_DIFF);
    end else if (d < -CLAMP_DIFF) begin
      r = CL_W'(-CLAMP_DIFF);
    end else begin
      r = d[CL_W-1:0];
    end
    return r;
  endfunction

endpackage

[hw/rtl/bezier_path_flattener.sv]
// Move and close: load, map, an optional closing edge, finish. Line: load, map, edge, plus
// any wait on the output register. Curve: load, map, diff, square, rhs, the step search
// (one candidate per cycle), den, then per edge weights, MAC, one-bit-per-cycle dividers.
// One command is in work at a time; the edge register lets the next command enter
// while the last beat still waits. Synchronous reset clears the origin, the current
// point, the contour start and the open flag; no clearing pass is needed.
module bezier_path_flattener import bpf_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  logic [135:0]   s_tdata,  // to_x, to_y, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y, 4 pad
  input  logic [2:0]     s_tuser,  // kind
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [127:0]   m_tdata,  // edge_x0, edge_y0, edge_x1, edge_y1
  output logic           m_tlast,
  input  logic           cfg_we,
  input  logic [0:0]     cfg_index,
  input  logic [21:0]    cfg_data
);

  `include "assert_macros.svh"

  logic signed [COORD_W-1:0] origin_x, origin_y;
  cmd_t cmd;
  sts_t sts;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x <= '0;
      origin_y <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ORIGIN_X: origin_x <= cfg_data;
        REG_ORIGIN_Y: origin_y <= cfg_data;
        default:      origin_x <= origin_x;
      endcase
    end
  end

  bpf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .sts      (sts),
    .cmd      (cmd)
  );

  bpf_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .origin_x (origin_x),
    .origin_y (origin_y),
    .in_pts   (s_tdata[6*COORD_W-1:0]),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  `ASSERT_IMPLIES(a_emit_free, cmd.emit, sts.out_free, "edge beat overwritten before taken")
  `ASSERT_IMPLIES(a_div_idle, cmd.div_start, !sts.div_busy, "divider restarted while busy")
  `ASSERT_IMPLIES(a_ready_idle, s_tready, !sts.div_busy, "input taken while division runs")

endmodule

[hw/rtl/bpf_div.sv]
// Restoring divider: floor of a signed numerator by a positive denominator.
module bpf_div import bpf_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [ACC_W-1:0] num,
  input  logic [DEN_W-1:0]        den,
  output logic                    busy,
  output logic [PT_W-1:0]         quo
);

  logic [DEN_W-1:0]  rem;
  logic [QUO_W-1:0]  q;
  logic [DCNT_W-1:0] cnt;
  logic              neg;
  logic [ACC_W-2:0]  mag;
  logic [DEN_W:0]    shifted;
  logic [DEN_W:0]    trial;

  // floor(s/d) for negative s is the complement of floor(~s/d)
  assign mag     = num[ACC_W-1] ? ~num[ACC_W-2:0] : num[ACC_W-2:0];
  assign shifted = {rem, q[QUO_W-1]};
  assign trial   = shifted - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == DCNT_W'(QUO_W - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= num[ACC_W-1];
      rem <= mag[ACC_W-2:QUO_W];
      q   <= mag[QUO_W-1:0];
    end else if (busy) begin
      if (!trial[DEN_W]) begin
        rem <= trial[DEN_W-1:0];
        q   <= {q[QUO_W-2:0], 1'b1};
      end else begin
        rem <= shifted[DEN_W-1:0];
        q   <= {q[QUO_W-2:0], 1'b0};
      end
    end
  end

  assign quo = neg ? ~q[PT_W-1:0] : q[PT_W-1:0];

endmodule

[hw/rtl/bpf_dp.sv]
// Datapath: point mapping, step search, Bernstein sums, dividers, edge register.
module bpf_dp import bpf_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  cmd_t                      cmd,
  output sts_t                      sts,
  input  logic signed [COORD_W-1:0] origin_x,
  input  logic signed [COORD_W-1:0] origin_y,
  input  logic [6*COORD_W-1:0]      in_pts,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [4*PT_W-1:0]         m_tdata,
  output logic                      m_tlast
);

  logic [COORD_W-1:0] raw_x [3];
  logic [COORD_W-1:0] raw_y [3];
  logic [PT_W-1:0]    map_x [3];
  logic [PT_W-1:0]    map_y [3];

  logic signed [PT_W-1:0] to_x, to_y;
  logic signed [PT_W-1:0] term_x [4];
  logic signed [PT_W-1:0] term_y [4];
  logic signed [PT_W-1:0] cur_x, cur_y, start_x, start_y;
  logic                   contour_open;

  logic signed [CL_W-1:0]   cl [4];
  logic signed [DIFF_W-1:0] dsum [4];
  logic [SQ_W-1:0]          sq [4];
  logic signed [2*CL_W-1:0] sq_full [4];
  logic [RHS_W-1:0]         rhs [2];
  logic [SQ_W:0]            rsum [2];

  logic [N_W-1:0]   n, i, u, t;
  logic [NSQ_W-1:0] nsq, uu, tt, ut;
  logic [N4_W-1:0]  n4;
  logic [RHS_W-1:0] lhs;
  logic [DEN_W-1:0] den;
  logic [W_W-1:0]   w [4];
  logic [2:0]       j;

  logic signed [ACC_W-1:0] prod_x, prod_y, acc_x, acc_y;
  logic                    busy_x, busy_y;
  logic [PT_W-1:0]         quo_x, quo_y;
  logic signed [PT_W-1:0]  end_x, end_y;
  logic                    out_free;

  // map raw 26.6 points into cell pixels; index 0 end point, 1 and 2 controls
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      map_x[k] = map_sat($signed({raw_x[k][COORD_W-1], raw_x[k]})
                         - $signed({origin_x[COORD_W-1], origin_x}));
      map_y[k] = map_sat($signed({origin_y[COORD_W-1], origin_y})
                         - $signed({raw_y[k][COORD_W-1], raw_y[k]}));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int k = 0; k < 3; k++) begin
        raw_x[k] <= in_pts[2*k*COORD_W +: COORD_W];
        raw_y[k] <= in_pts[(2*k+1)*COORD_W +: COORD_W];
      end
    end
    if (cmd.map) begin
      to_x      <= map_x[0];
      to_y      <= map_y[0];
      term_x[0] <= cur_x;
      term_y[0] <= cur_y;
      term_x[1] <= map_x[1];
      term_y[1] <= map_y[1];
      term_x[2] <= cmd.cubic ? map_x[2] : map_x[0];
      term_y[2] <= cmd.cubic ? map_y[2] : map_y[0];
      term_x[3] <= cmd.cubic ? map_x[0] : '0;
      term_y[3] <= cmd.cubic ? map_y[0] : '0;
    end
  end

  // second differences: cl 0/1 first x/y, 2/3 second x/y
  always_comb begin
    dsum[0] = DIFF_W'(term_x[0]) - (DIFF_W'(term_x[1]) <<< 1) + DIFF_W'(term_x[2]);
    dsum[1] = DIFF_W'(term_y[0]) - (DIFF_W'(term_y[1]) <<< 1) + DIFF_W'(term_y[2]);
    dsum[2] = DIFF_W'(term_x[1]) - (DIFF_W'(term_x[2]) <<< 1) + DIFF_W'(term_x[3]);
    dsum[3] = DIFF_W'(term_y[1]) - (DIFF_W'(term_y[2]) <<< 1) + DIFF_W'(term_y[3]);
    for (int k = 0; k < 4; k++) begin
      sq_full[k] = cl[k] * cl[k];
    end
    rsum[0] = {1'b0, sq[0]} + {1'b0, sq[1]};
    rsum[1] = {1'b0, sq[2]} + {1'b0, sq[3]};
  end

  always_ff @(posedge clk) begin
    if (cmd.diff) begin
      for (int k = 0; k < 4; k++) begin
        cl[k] <= clamp_diff(dsum[k]);
      end
    end
    if (cmd.sqr) begin
      for (int k = 0; k < 4; k++) begin
        sq[k] <= sq_full[k][SQ_W-1:0];
      end
    end
    if (cmd.rhs) begin
      for (int k = 0; k < 2; k++) begin
        rhs[k] <= cmd.cubic ? (RHS_W'(rsum[k]) << 3) + RHS_W'(rsum[k]) : RHS_W'(rsum[k]);
      end
    end
  end

  // step search: smallest n with (n*n*scale)^2 covering the deviation, capped at MAX_STEPS
  assign n4  = nsq * nsq;
  assign lhs = cmd.cubic ? (RHS_W'(n4) << SHIFT_CUBIC) : (RHS_W'(n4) << SHIFT_QUAD);

  assign sts.search_hit = ((lhs >= rhs[0]) && (!cmd.cubic || (lhs >= rhs[1])))
                          || (n == N_W'(MAX_STEPS));

  assign u = n - i;
  assign t = i;

  always_ff @(posedge clk) begin
    if (cmd.rhs) begin
      n   <= N_W'(1);
      nsq <= NSQ_W'(1);
    end else if (cmd.search && !sts.search_hit) begin
      n   <= n + 1'b1;
      nsq <= nsq + NSQ_W'({n, 1'b0}) + NSQ_W'(1);
    end
    if (cmd.den) begin
      den <= cmd.cubic ? DEN_W'(nsq) * DEN_W'(n) : DEN_W'(nsq);
      i   <= N_W'(1);
    end else if (cmd.step_next) begin
      i <= i + 1'b1;
    end
    if (cmd.wgt1) begin
      uu <= NSQ_W'(u) * NSQ_W'(u);
      tt <= NSQ_W'(t) * NSQ_W'(t);
      ut <= NSQ_W'(u) * NSQ_W'(t);
    end
    if (cmd.wgt2) begin
      w[0] <= cmd.cubic ? W_W'(uu) * W_W'(u) : W_W'(uu);
      w[1] <= cmd.cubic ? W_W'(uu) * W_W'(t) * W_W'(3) : W_W'({ut, 1'b0});
      w[2] <= cmd.cubic ? W_W'(tt) * W_W'(u) * W_W'(3) : W_W'(tt);
      w[3] <= cmd.cubic ? W_W'(tt) * W_W'(t) : '0;
    end
  end

  // accumulate the four weighted terms, one product per cycle and axis
  always_ff @(posedge clk) begin
    if (cmd.wgt2) begin
      j     <= '0;
      acc_x <= ACC_W'(den >> 1);
      acc_y <= ACC_W'(den >> 1);
    end else if (cmd.mac) begin
      j <= j + 1'b1;
      if (j < 3'd4) begin
        prod_x <= ACC_W'($signed({1'b0, w[j[1:0]]})) * ACC_W'(term_x[j[1:0]]);
        prod_y <= ACC_W'($signed({1'b0, w[j[1:0]]})) * ACC_W'(term_y[j[1:0]]);
      end
      if (j != 3'd0) begin
        acc_x <= acc_x + prod_x;
        acc_y <= acc_y + prod_y;
      end
    end
  end

  bpf_div u_div_x (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (acc_x),
    .den   (den),
    .busy  (busy_x),
    .quo   (quo_x)
  );

  bpf_div u_div_y (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (acc_y),
    .den   (den),
    .busy  (busy_y),
    .quo   (quo_y)
  );

  always_comb begin
    unique case (cmd.end_sel)
      END_START: begin
        end_x = start_x;
        end_y = start_y;
      end
      END_TO: begin
        end_x = to_x;
        end_y = to_y;
      end
      END_CURVE: begin
        end_x = quo_x;
        end_y = quo_y;
      end
      default: begin
        end_x = to_x;
        end_y = to_y;
      end
    endcase
  end

  assign out_free = !m_tvalid || m_tready;

  // contour state
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x        <= '0;
      cur_y        <= '0;
      start_x      <= '0;
      start_y      <= '0;
      contour_open <= 1'b0;
    end else begin
      if (cmd.emit) begin
        cur_x <= end_x;
        cur_y <= end_y;
      end else if (cmd.set_point) begin
        cur_x   <= to_x;
        cur_y   <= to_y;
        start_x <= to_x;
        start_y <= to_y;
      end
      if (cmd.set_point) begin
        contour_open <= 1'b1;
      end else if (cmd.clear_open) begin
        contour_open <= 1'b0;
      end
    end
  end

  // output register: hold the beat until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      m_tdata <= {end_y, end_x, cur_y, cur_x};
      m_tlast <= cmd.last;
    end
  end

  assign sts.close_due = contour_open && ((cur_x != start_x) || (cur_y != start_y));
  assign sts.div_busy  = busy_x || busy_y;
  assign sts.mac_last  = (j == 3'd4);
  assign sts.step_last = (i == n);
  assign sts.out_free  = out_free;

endmodule

[hw/rtl/bpf_ctrl.sv]
// Controller state machine sequencing the flattener datapath per command.
module bpf_ctrl import bpf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [2:0] s_tuser,
  input  sts_t       sts,
  output cmd_t       cmd
);

  state_t state, state_next;
  kind_t  kind;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      kind  <= KIND_MOVE;
    end else begin
      state <= state_next;
      if (s_tvalid && s_tready) begin
        kind <= kind_t'(s_tuser);
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = ST_MAP;
        end
      end
      ST_MAP: begin
        unique case (kind)
          KIND_MOVE, KIND_CLOSE: state_next = sts.close_due ? ST_CLOSE_EDGE : ST_FINISH;
          KIND_LINE:             state_next = ST_LINE_EDGE;
          KIND_QUAD, KIND_CUBIC: state_next = ST_DIFF;
          default:               state_next = ST_IDLE;
        endcase
      end
      ST_CLOSE_EDGE: begin
        if (sts.out_free) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH:    state_next = ST_IDLE;
      ST_LINE_EDGE: begin
        if (sts.out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_DIFF:      state_next = ST_SQR;
      ST_SQR:       state_next = ST_RHS;
      ST_RHS:       state_next = ST_SEARCH;
      ST_SEARCH: begin
        if (sts.search_hit) begin
          state_next = ST_DEN;
        end
      end
      ST_DEN:       state_next = ST_WGT1;
      ST_WGT1:      state_next = ST_WGT2;
      ST_WGT2:      state_next = ST_MAC;
      ST_MAC: begin
        if (sts.mac_last) begin
          state_next = ST_DIV_START;
        end
      end
      ST_DIV_START: state_next = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (!sts.div_busy) begin
          state_next = ST_STEP_EDGE;
        end
      end
      ST_STEP_EDGE: begin
        if (sts.out_free) begin
          state_next = sts.step_last ? ST_IDLE : ST_WGT1;
        end
      end
      default:      state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd         = '0;
    cmd.end_sel = END_TO;
    cmd.cubic   = (kind == KIND_CUBIC);
    s_tready    = (state == ST_IDLE);
    unique case (state)
      ST_IDLE:       cmd.load = s_tvalid;
      ST_MAP:        cmd.map = 1'b1;
      ST_CLOSE_EDGE: begin
        cmd.emit    = sts.out_free;
        cmd.end_sel = END_START;
        cmd.last    = 1'b1;
      end
      ST_FINISH: begin
        cmd.set_point  = (kind == KIND_MOVE);
        cmd.clear_open = (kind == KIND_CLOSE);
      end
      ST_LINE_EDGE: begin
        cmd.emit = sts.out_free;
        cmd.last = 1'b1;
      end
      ST_DIFF:       cmd.diff = 1'b1;
      ST_SQR:        cmd.sqr = 1'b1;
      ST_RHS:        cmd.rhs = 1'b1;
      ST_SEARCH:     cmd.search = 1'b1;
      ST_DEN:        cmd.den = 1'b1;
      ST_WGT1:       cmd.wgt1 = 1'b1;
      ST_WGT2:       cmd.wgt2 = 1'b1;
      ST_MAC:        cmd.mac = 1'b1;
      ST_DIV_START:  cmd.div_start = 1'b1;
      ST_DIV_WAIT:   cmd.div_start = 1'b0;
      ST_STEP_EDGE: begin
        cmd.emit      = sts.out_free;
        cmd.end_sel   = END_CURVE;
        cmd.last      = sts.step_last;
        cmd.step_next = sts.out_free;
      end
      default:       cmd.load = 1'b0;
    endcase
  end

endmodule

[test/bezier_path_flattener_test.sv]
// Testbench for the Bezier path flattener: path command stream in, predicted edges checked out.
`timescale 1ns / 100ps

module bezier_path_flattener_test;
  import bpf_pkg::*;

  typedef struct {
    logic [2:0]         kind;
    logic signed [21:0] tx, ty, c1x, c1y, c2x, c2y;
  } path_cmd_t;

  typedef struct {
    logic signed [31:0] x0, y0, x1, y1;
    logic               last;
  } edge_rec_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [135:0] s_tdata = '0;   // to_x, to_y, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y, 4 pad
  logic [2:0]   s_tuser = '0;   // kind
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [127:0] m_tdata;        // edge_x0, edge_y0, edge_x1, edge_y1
  logic         m_tlast;
  logic         cfg_we = 1'b0;
  logic [0:0]   cfg_index = '0;
  logic [21:0]  cfg_data = '0;

  bezier_path_flattener dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  path_cmd_t cmd_q[$];
  edge_rec_t edge_q[$];
  int        errors = 0;
  int        beats_seen = 0;

  // predictor state
  longint org_x = 0, org_y = 0;
  int     pen_x = 0, pen_y = 0, first_x = 0, first_y = 0;
  bit     is_open = 0;

  function automatic void queue_cmd(path_cmd_t c);
    cmd_q.insert(cmd_q.size(), c);
  endfunction

  function automatic int sat32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return int'(v);
  endfunction

  function automatic int to_px(logic signed [21:0] c);
    return sat32((longint'(c) - org_x) * 1024);
  endfunction

  function automatic int to_py(logic signed [21:0] c);
    return sat32((org_y - longint'(c)) * 1024);
  endfunction

  function automatic longint clip_diff(longint v);
    if (v > 64'sd33554432) return 64'sd33554432;
    if (v < -64'sd33554432) return -64'sd33554432;
    return v;
  endfunction

  function automatic int piece_count(longint dx, longint dy, longint scale, longint mult);
    longint a, b, rhs, l;
    a = clip_diff(dx);
    b = clip_diff(dy);
    rhs = mult * (a * a + b * b);
    for (int n = 1; n < MAX_STEPS; n++) begin
      l = longint'(n) * n * scale;
      if (l * l >= rhs) return n;
    end
    return MAX_STEPS;
  endfunction

  // round to nearest, ties up
  function automatic int round_div(longint num, longint den);
    longint s, q;
    s = num + den / 2;
    q = s / den;
    if (s % den < 0) q--;
    return sat32(q);
  endfunction

  function automatic void push_edge(int x1, int y1);
    edge_rec_t e;
    e.x0 = pen_x; e.y0 = pen_y; e.x1 = x1; e.y1 = y1; e.last = 1'b0;
    edge_q.insert(edge_q.size(), e);
    pen_x = x1;
    pen_y = y1;
  endfunction

  function automatic void close_contour();
    if (is_open && (pen_x != first_x || pen_y != first_y)) push_edge(first_x, first_y);
    is_open = 0;
  endfunction

  function automatic void flatten_cmd(path_cmd_t c);
    int     prior_cnt, n, n2;
    longint x0, y0, ax, ay, bx, by, ex, ey, den, u, t, wa, wb, wc, wd;
    prior_cnt = edge_q.size();
    x0 = pen_x; y0 = pen_y;
    ax = to_px(c.c1x); ay = to_py(c.c1y);
    bx = to_px(c.c2x); by = to_py(c.c2y);
    ex = to_px(c.tx);  ey = to_py(c.ty);
    case (c.kind)
      KIND_MOVE: begin
        close_contour();
        pen_x = int'(ex); first_x = int'(ex);
        pen_y = int'(ey); first_y = int'(ey);
        is_open = 1;
      end
      KIND_LINE: push_edge(int'(ex), int'(ey));
      KIND_QUAD: begin
        n = piece_count(x0 - 2 * ax + ex, y0 - 2 * ay + ey, 4096, 1);
        den = longint'(n) * n;
        for (int i = 1; i <= n; i++) begin
          u = n - i; t = i;
          wa = u * u; wb = 2 * u * t; wc = t * t;
          push_edge(round_div(wa * x0 + wb * ax + wc * ex, den),
                    round_div(wa * y0 + wb * ay + wc * ey, den));
        end
      end
      KIND_CUBIC: begin
        n = piece_count(x0 - 2 * ax + bx, y0 - 2 * ay + by, 2048, 9);
        n2 = piece_count(ax - 2 * bx + ex, ay - 2 * by + ey, 2048, 9);
        if (n2 > n) n = n2;
        den = longint'(n) * n * n;
        for (int i = 1; i <= n; i++) begin
          u = n - i; t = i;
          wa = u * u * u; wb = 3 * u * u * t; wc = 3 * u * t * t; wd = t * t * t;
          push_edge(round_div(wa * x0 + wb * ax + wc * bx + wd * ex, den),
                    round_div(wa * y0 + wb * ay + wc * by + wd * ey, den));
        end
      end
      KIND_CLOSE: close_contour();
      default: ;
    endcase
    if (edge_q.size() > prior_cnt) edge_q[edge_q.size() - 1].last = 1'b1;
  endfunction

  // sender
  path_cmd_t cur_cmd;
  int        send_gap = 0;
  bit        send_quiet = 0;
  bit        nxt_valid;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      nxt_valid = s_tvalid;
      if (s_tvalid && s_tready) begin
        flatten_cmd(cur_cmd);
        if ($urandom_range(0, 29) == 0) send_quiet = !send_quiet;
        send_gap = send_quiet ? 0 : $urandom_range(0, 5);
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (cmd_q.size() > 0) begin
          cur_cmd = cmd_q.pop_front();
          s_tdata <= {4'b0, cur_cmd.c2y, cur_cmd.c2x, cur_cmd.c1y, cur_cmd.c1x,
                      cur_cmd.ty, cur_cmd.tx};
          s_tuser <= cur_cmd.kind;
          nxt_valid = 1'b1;
        end
      end
      s_tvalid <= nxt_valid;
    end
  end

  // receiver
  int        recv_hold = 0;
  bit        recv_quiet = 0;
  edge_rec_t want;

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (recv_hold > 0) recv_hold--;
      if (m_tvalid && m_tready) begin
        beats_seen++;
        if (edge_q.size() == 0) begin
          $error("edge beat with nothing expected: %h last %b", m_tdata, m_tlast);
          errors++;
        end else begin
          want = edge_q.pop_front();
          if ($signed(m_tdata[31:0]) != want.x0) begin
            $error("edge_x0 expected %0d got %0d", want.x0, $signed(m_tdata[31:0]));
            errors++;
          end
          if ($signed(m_tdata[63:32]) != want.y0) begin
            $error("edge_y0 expected %0d got %0d", want.y0, $signed(m_tdata[63:32]));
            errors++;
          end
          if ($signed(m_tdata[95:64]) != want.x1) begin
            $error("edge_x1 expected %0d got %0d", want.x1, $signed(m_tdata[95:64]));
            errors++;
          end
          if ($signed(m_tdata[127:96]) != want.y1) begin
            $error("edge_y1 expected %0d got %0d", want.y1, $signed(m_tdata[127:96]));
            errors++;
          end
          if (m_tlast != want.last) begin
            $error("last expected %0d got %0d", want.last, m_tlast);
            errors++;
          end
        end
        if ($urandom_range(0, 29) == 0) recv_quiet = !recv_quiet;
        recv_hold = recv_quiet ? 0 : $urandom_range(0, 5);
        // long hold-off so the edge register fills and the input stalls
        if (beats_seen == 40) recv_hold = 400;
      end
      m_tready <= (recv_hold == 0);
    end
  end

  function automatic path_cmd_t mk(logic [2:0] k, longint tx, longint ty,
                                   longint ax = 0, longint ay = 0,
                                   longint bx = 0, longint by = 0);
    path_cmd_t c;
    c.kind = k;
    c.tx = 22'(tx); c.ty = 22'(ty);
    c.c1x = 22'(ax); c.c1y = 22'(ay);
    c.c2x = 22'(bx); c.c2y = 22'(by);
    return c;
  endfunction

  function automatic longint rnd22();
    logic signed [21:0] v;
    v = 22'($urandom);
    return longint'(v);
  endfunction

  function automatic longint near(longint base, int r);
    longint v;
    v = base + longint'($urandom_range(0, 2 * r)) - r;
    if (v > 2097151) v = 2097151;
    if (v < -2097152) v = -2097152;
    return v;
  endfunction

  function automatic int pick_reach();
    int p;
    p = $urandom_range(0, 99);
    if (p < 70) return $urandom_range(64, 512);
    if (p < 95) return $urandom_range(512, 8192);
    return 2097152;
  endfunction

  // well-formed contours with random content, plus some noise
  function automatic void random_path(int target);
    int     made, r, segs;
    longint px, py, ax, ay;
    path_cmd_t c;
    made = 0;
    while (made < target) begin
      if ($urandom_range(0, 9) == 0) begin
        c = mk(3'($urandom_range(0, 7)), rnd22(), rnd22(), rnd22(), rnd22(), rnd22(), rnd22());
        queue_cmd(c);
        if (c.kind <= KIND_CLOSE) made++;
        continue;
      end
      px = rnd22(); py = rnd22();
      queue_cmd(mk(KIND_MOVE, px, py, rnd22(), rnd22(), rnd22(), rnd22()));
      made++;
      segs = $urandom_range(1, 6);
      for (int s = 0; s < segs; s++) begin
        r = pick_reach();
        ax = near(px, r); ay = near(py, r);
        c = mk(3'($urandom_range(1, 3)), near(px, r), near(py, r), ax, ay,
               near(ax, r), near(ay, r));
        queue_cmd(c);
        px = c.tx; py = c.ty;
        made++;
      end
      if ($urandom_range(0, 2) != 0) begin
        queue_cmd(mk(KIND_CLOSE, rnd22(), rnd22(), rnd22(), rnd22(), rnd22(), rnd22()));
        made++;
      end
    end
  endfunction

  task automatic write_reg(logic [0:0] idx, longint v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= 22'(v);
    if (idx == REG_ORIGIN_Y) org_y = longint'($signed(22'(v)));
    else org_x = longint'($signed(22'(v)));
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (cmd_q.size() > 0 || s_tvalid || edge_q.size() > 0) @(posedge clk);
    // a trailing move or close may still be in work with no edge due
    repeat (20) @(posedge clk);
  endtask

  longint ox_set[5] = '{0, -2097152, 2097151, 0, 12345};
  longint oy_set[5] = '{0, 2097151, -2097152, 0, -777};

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    for (int ph = 0; ph < 5; ph++) begin
      if (ph == 3) begin
        ox_set[3] = rnd22();
        oy_set[3] = rnd22();
      end
      write_reg(REG_ORIGIN_X, ox_set[ph]);
      write_reg(REG_ORIGIN_Y, oy_set[ph]);
      if (ph == 0) begin
        queue_cmd(mk(KIND_LINE, 100, -50));
        queue_cmd(mk(KIND_QUAD, 300, 0, 200, 200));
        queue_cmd(mk(KIND_CUBIC, 0, 0, 100, 300, 400, -300));
        queue_cmd(mk(KIND_CLOSE, 5, 5));
        queue_cmd(mk(KIND_MOVE, 2097151, 2097151, -1, -1, -1, -1));
        queue_cmd(mk(KIND_LINE, -2097152, -2097152, -1, -1, -1, -1));
        queue_cmd(mk(KIND_MOVE, 0, 0));
        queue_cmd(mk(KIND_LINE, 640, 0));
        queue_cmd(mk(KIND_QUAD, 1280, 0, 960, 0, 55, 66)); // flat: one piece
        queue_cmd(mk(KIND_CUBIC, 640, 640, 1500, 300, 900, 900));
        queue_cmd(mk(KIND_CLOSE, 0, 0));
        queue_cmd(mk(KIND_CLOSE, 0, 0));
        queue_cmd(mk(KIND_MOVE, 10, 10));
        queue_cmd(mk(KIND_MOVE, 20, 20));   // nothing drawn: no closing edge
        queue_cmd(mk(KIND_LINE, 200, 20));
        queue_cmd(mk(KIND_LINE, 20, 20));
        queue_cmd(mk(KIND_CLOSE, 0, 0));   // back at start: no edge
        queue_cmd(mk(KIND_MOVE, -300, 400));
        queue_cmd(mk(KIND_LINE, 100, 100));
        queue_cmd(mk(KIND_MOVE, 0, 0));    // closes the open contour
        queue_cmd(mk(3'd5, -1, -1, -1, -1, -1, -1));
        queue_cmd(mk(3'd6, 2097151, -2097152, 1, 2, 3, 4));
        queue_cmd(mk(3'd7, 0, 0, -2097152, 2097151, -2097152, 2097151));
        queue_cmd(mk(KIND_QUAD, 0, 0, 2097151, -2097152));       // n saturates
        queue_cmd(mk(KIND_CUBIC, 0, 0, 2097151, 2097151, -2097152, -2097152));
      end
      random_path(40);
      drain();
    end
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

[bezier_path_flattener.f]
+incdir+hw/rtl
hw/rtl/bpf_pkg.sv
hw/rtl/bpf_div.sv
hw/rtl/bpf_dp.sv
hw/rtl/bpf_ctrl.sv
hw/rtl/bezier_path_flattener.sv
test/bezier_path_flattener_test.sv
